// File: sv/fmp_pkg.sv
package fmp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  // Reject reasons
  typedef enum logic [1:0] {
    RSN_SYNC  = 2'd0,
    RSN_SHORT = 2'd1,
    RSN_EARLY = 2'd2
  } reason_t;

  // Frame constants
  localparam logic [7:0]  SYNC_BYTE = 8'h55;
  localparam logic [7:0]  HCRC_INIT = 8'hEE;
  localparam logic [7:0]  HCRC_POLY = 8'h31;
  localparam logic [15:0] BCRC_INIT = 16'h496C;
  localparam logic [15:0] BCRC_POLY = 16'h1021;
  localparam logic [9:0]  MIN_LEN   = 10'd13;

  // Header byte positions
  localparam logic [9:0] POS_SYNC    = 10'd0;
  localparam logic [9:0] POS_LEN_LO  = 10'd1;
  localparam logic [9:0] POS_LEN_HI  = 10'd2;
  localparam logic [9:0] POS_HCRC    = 10'd3;
  localparam logic [9:0] POS_SENDER  = 10'd4;
  localparam logic [9:0] POS_RECVR   = 10'd5;
  localparam logic [9:0] POS_ID_HI   = 10'd6;
  localparam logic [9:0] POS_ID_LO   = 10'd7;
  localparam logic [9:0] POS_FLAGS   = 10'd8;
  localparam logic [9:0] POS_CMD_SET = 10'd9;
  localparam logic [9:0] POS_CMD_ID  = 10'd10;
  localparam logic [9:0] POS_PAYLOAD = 10'd11;

  // One result beat
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [9:0]  frame_length;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [15:0] msg_id;
    logic [7:0]  flag_bits;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic        crc_ok;
    reason_t     reject_reason;
  } result_t;

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] mirror16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  // Reflected CRC-8 update over one byte
  function automatic logic [7:0] fold8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ mirror8(b);
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ HCRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Reflected CRC-16 update over one byte
  function automatic logic [15:0] fold16(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {mirror8(b), 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ BCRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/framed_message_parser_crc.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | data_byte, last_of_buffer
// out_    | output    | out_valid/out_stall | kind, payload and header fields,
//         |           |                     | crc_ok, reject_reason
//
// One byte is taken per cycle while in_stall is low; its result, if any, is registered in the
// output buffer before it shows on out_. Header CRC-8 and body CRC-16 each fold in a whole byte combinationally.
// rst_n is synchronous, active low; the parser restarts at byte 0 of a frame.
// A two-entry output buffer (register plus skid) decouples the sides: in_stall
// rises only while both entries hold results that out_stall keeps waiting.
module framed_message_parser_crc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [9:0]  out_payload_index,
  output logic [9:0]  out_frame_length,
  output logic [7:0]  out_sender,
  output logic [7:0]  out_receiver,
  output logic [15:0] out_msg_id,
  output logic [7:0]  out_flag_bits,
  output logic [7:0]  out_command_set,
  output logic [7:0]  out_command_id,
  output logic        out_crc_ok,
  output logic [1:0]  out_reject_reason
);

  typedef enum logic [1:0] {
    PH_RECV = 2'b01,
    PH_DISC = 2'b10
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [7:0]  hcrc_r, hcrc_nxt;
  logic [15:0] bcrc_r, bcrc_nxt;
  logic        hmatch_r, hmatch_nxt;
  logic [7:0]  sender_r, sender_nxt;
  logic [7:0]  recvr_r, recvr_nxt;
  logic [15:0] msg_id_r, msg_id_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  trl_lo_r, trl_lo_nxt;

  logic             in_acc;
  logic             full;
  logic             res_vld;
  logic             ended;
  fmp_pkg::result_t res;
  fmp_pkg::result_t out_data;
  logic [10:0]      pos_p2;
  logic [10:0]      len_ext;
  logic             in_body;
  logic             at_trl_lo;
  logic [7:0]       hcrc_base;
  logic [15:0]      bcrc_base;
  logic [9:0]       len_new;

  assign in_stall  = full;
  assign in_acc    = in_valid && !full;
  assign pos_p2    = {1'b0, pos_r} + 11'd2;
  assign len_ext   = {1'b0, len_r};
  assign in_body   = pos_p2 < len_ext;
  assign at_trl_lo = pos_p2 == len_ext;
  assign hcrc_base = (pos_r == fmp_pkg::POS_SYNC) ? fmp_pkg::HCRC_INIT : hcrc_r;
  assign bcrc_base = (pos_r == fmp_pkg::POS_SYNC) ? fmp_pkg::BCRC_INIT : bcrc_r;
  assign len_new   = {in_data_byte[1:0], len_r[7:0]};

  // Parse one byte: update CRCs, capture header fields, build the result
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    hcrc_nxt   = hcrc_r;
    bcrc_nxt   = bcrc_r;
    hmatch_nxt = hmatch_r;
    sender_nxt = sender_r;
    recvr_nxt  = recvr_r;
    msg_id_nxt = msg_id_r;
    flag_nxt   = flag_r;
    cmd_nxt    = cmd_r;
    trl_lo_nxt = trl_lo_r;
    res        = '0;
    res_vld    = 1'b0;
    ended      = 1'b0;

    if (in_acc) begin
      if (phase_r == PH_DISC) begin
        // drop bytes until the buffer ends
        if (in_last_of_buffer) begin
          phase_nxt = PH_RECV;
          pos_nxt   = '0;
        end
      end else begin
        // advance the checksums
        if (pos_r <= fmp_pkg::POS_LEN_HI) begin
          hcrc_nxt = fmp_pkg::fold8(hcrc_base, in_data_byte);
          bcrc_nxt = fmp_pkg::fold16(bcrc_base, in_data_byte);
        end else if (in_body) begin
          bcrc_nxt = fmp_pkg::fold16(bcrc_r, in_data_byte);
        end

        case (pos_r)
          fmp_pkg::POS_SYNC: begin
            if (in_data_byte != fmp_pkg::SYNC_BYTE) begin
              res_vld           = 1'b1;
              res.kind          = fmp_pkg::KIND_REJECT;
              res.reject_reason = fmp_pkg::RSN_SYNC;
              ended             = 1'b1;
            end
          end
          fmp_pkg::POS_LEN_LO:  len_nxt = {2'b00, in_data_byte};
          fmp_pkg::POS_LEN_HI: begin
            len_nxt = len_new;
            if (len_new < fmp_pkg::MIN_LEN) begin
              res_vld           = 1'b1;
              res.kind          = fmp_pkg::KIND_REJECT;
              res.reject_reason = fmp_pkg::RSN_SHORT;
              ended             = 1'b1;
            end
          end
          fmp_pkg::POS_HCRC:    hmatch_nxt = fmp_pkg::mirror8(hcrc_r) == in_data_byte;
          fmp_pkg::POS_SENDER:  sender_nxt = in_data_byte;
          fmp_pkg::POS_RECVR:   recvr_nxt = in_data_byte;
          fmp_pkg::POS_ID_HI:   msg_id_nxt = {in_data_byte, msg_id_r[7:0]};
          fmp_pkg::POS_ID_LO:   msg_id_nxt = {msg_id_r[15:8], in_data_byte};
          fmp_pkg::POS_FLAGS:   flag_nxt = in_data_byte;
          fmp_pkg::POS_CMD_SET: cmd_nxt = {in_data_byte, cmd_r[7:0]};
          fmp_pkg::POS_CMD_ID:  cmd_nxt = {cmd_r[15:8], in_data_byte};
          default: begin
            if (in_body) begin
              res_vld           = 1'b1;
              res.kind          = fmp_pkg::KIND_PAYLOAD;
              res.payload_byte  = in_data_byte;
              res.payload_index = pos_r - fmp_pkg::POS_PAYLOAD;
            end else if (at_trl_lo) begin
              trl_lo_nxt = in_data_byte;
            end else begin
              res_vld    = 1'b1;
              res.kind   = fmp_pkg::KIND_ACCEPT;
              res.crc_ok = hmatch_r &&
                           (fmp_pkg::mirror16(bcrc_r) == {in_data_byte, trl_lo_r});
              ended      = 1'b1;
            end
          end
        endcase

        // close the frame or step to the next byte
        if (in_last_of_buffer) begin
          if (!ended) begin
            res               = '0;
            res_vld           = 1'b1;
            res.kind          = fmp_pkg::KIND_REJECT;
            res.reject_reason = fmp_pkg::RSN_EARLY;
          end
          phase_nxt = PH_RECV;
          pos_nxt   = '0;
        end else if (ended) begin
          phase_nxt = PH_DISC;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_r + 10'd1;
        end

        // attach captured header to payload and accept beats
        if (res.kind != fmp_pkg::KIND_REJECT) begin
          res.frame_length = len_r;
          res.sender       = sender_r;
          res.receiver     = recvr_r;
          res.msg_id       = msg_id_r;
          res.flag_bits    = flag_r;
          res.command_set  = cmd_r[15:8];
          res.command_id   = cmd_r[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RECV;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    hcrc_r   <= hcrc_nxt;
    bcrc_r   <= bcrc_nxt;
    hmatch_r <= hmatch_nxt;
    sender_r <= sender_nxt;
    recvr_r  <= recvr_nxt;
    msg_id_r <= msg_id_nxt;
    flag_r   <= flag_nxt;
    cmd_r    <= cmd_nxt;
    trl_lo_r <= trl_lo_nxt;
  end

  // Hold results until the consumer takes them
  fmp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind          = out_data.kind;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;
  assign out_frame_length  = out_data.frame_length;
  assign out_sender        = out_data.sender;
  assign out_receiver      = out_data.receiver;
  assign out_msg_id        = out_data.msg_id;
  assign out_flag_bits     = out_data.flag_bits;
  assign out_command_set   = out_data.command_set;
  assign out_command_id    = out_data.command_id;
  assign out_crc_ok        = out_data.crc_ok;
  assign out_reject_reason = out_data.reject_reason;

endmodule

// File: sv/fmp_outbuf.sv
module fmp_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fmp_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output fmp_pkg::result_t out_data
);

  logic             out_vld_r, out_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  fmp_pkg::result_t out_data_r, out_data_nxt;
  fmp_pkg::result_t skid_data_r, skid_data_nxt;
  logic             take;

  assign take      = out_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Advance skid into output, place a new beat where there is room, or empty the output once taken
  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (skid_vld_r) begin
      if (take) begin
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || take) begin
        out_data_nxt = push_data;
        out_vld_nxt  = 1'b1;
      end else begin
        skid_data_nxt = push_data;
        skid_vld_nxt  = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// File: sv/fmp_checker.sv
module fmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_last_of_buffer,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_payload_byte,
  input logic [9:0]  out_payload_index,
  input logic [9:0]  out_frame_length,
  input logic [7:0]  out_sender,
  input logic [7:0]  out_receiver,
  input logic [15:0] out_msg_id,
  input logic [7:0]  out_flag_bits,
  input logic [7:0]  out_command_set,
  input logic [7:0]  out_command_id,
  input logic        out_crc_ok,
  input logic [1:0]  out_reject_reason
);

  // Hold a stalled input beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) &&
      $stable(in_last_of_buffer))
    else $error("stalled input beat changed");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_payload_byte) && $stable(out_payload_index) &&
      $stable(out_frame_length) && $stable(out_sender) && $stable(out_receiver) &&
      $stable(out_msg_id) && $stable(out_flag_bits) && $stable(out_command_set) &&
      $stable(out_command_id) && $stable(out_crc_ok) && $stable(out_reject_reason))
    else $error("stalled result beat changed");

  // Payload index stays inside the declared body
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fmp_pkg::KIND_PAYLOAD |->
      ({1'b0, out_payload_index} + 11'd13) < {1'b0, out_frame_length})
    else $error("payload index beyond frame body");

  // Reject beats carry only a reason
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fmp_pkg::KIND_REJECT |->
      out_frame_length == 10'd0 && out_msg_id == 16'd0 && out_crc_ok == 1'b0 &&
      out_payload_byte == 8'd0 && out_sender == 8'd0)
    else $error("reject beat carries header data");

  // Payload and accept beats carry a legal length and no reason
  a_frame_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == fmp_pkg::KIND_PAYLOAD || out_kind == fmp_pkg::KIND_ACCEPT)
      |-> out_frame_length >= fmp_pkg::MIN_LEN && out_reject_reason == 2'd0)
    else $error("frame beat with bad length or reason");

endmodule

bind framed_message_parser_crc fmp_checker u_fmp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_data_byte      (in_data_byte),
  .in_last_of_buffer (in_last_of_buffer),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_frame_length  (out_frame_length),
  .out_sender        (out_sender),
  .out_receiver      (out_receiver),
  .out_msg_id        (out_msg_id),
  .out_flag_bits     (out_flag_bits),
  .out_command_set   (out_command_set),
  .out_command_id    (out_command_id),
  .out_crc_ok        (out_crc_ok),
  .out_reject_reason (out_reject_reason)
);

// File: bench/tb_framed_message_parser_crc.sv
`timescale 1ns / 100ps

module tb_framed_message_parser_crc;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 37;
  localparam int N_ITEMS     = 1150;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef enum logic {
    PH_RECV    = 1'b0,
    PH_DISCARD = 1'b1
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [9:0]  out_payload_index;
  logic [9:0]  out_frame_length;
  logic [7:0]  out_sender;
  logic [7:0]  out_receiver;
  logic [15:0] out_msg_id;
  logic [7:0]  out_flag_bits;
  logic [7:0]  out_command_set;
  logic [7:0]  out_command_id;
  logic        out_crc_ok;
  logic [1:0]  out_reject_reason;

  framed_message_parser_crc dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_of_buffer (in_last_of_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_length  (out_frame_length),
    .out_sender        (out_sender),
    .out_receiver      (out_receiver),
    .out_msg_id        (out_msg_id),
    .out_flag_bits     (out_flag_bits),
    .out_command_set   (out_command_set),
    .out_command_id    (out_command_id),
    .out_crc_ok        (out_crc_ok),
    .out_reject_reason (out_reject_reason)
  );

  in_beat_t          pending_bytes [$];
  fmp_pkg::result_t  expected_results [$];

  int cycle_cnt   = 0;
  int acc_cnt     = 0;
  int err_cnt     = 0;
  int rst_hold    = 0;
  logic in_fire   = 1'b0;

  // Parser shadow state
  parse_phase_t ps_phase = PH_RECV;
  logic [9:0]   ps_pos = '0;
  logic [9:0]   ps_len = '0;
  logic [7:0]   ps_hcrc = fmp_pkg::HCRC_INIT;
  logic [15:0]  ps_bcrc = fmp_pkg::BCRC_INIT;
  logic         ps_hdr_ok = 1'b0;
  logic [7:0]   ps_sender = '0;
  logic [7:0]   ps_receiver = '0;
  logic [15:0]  ps_msg_id = '0;
  logic [7:0]   ps_flags = '0;
  logic [7:0]   ps_cmd_set = '0;
  logic [7:0]   ps_cmd_id = '0;
  logic [7:0]   ps_trail_lo = '0;

  // Hold both sides busy during a stretch in the middle of the run
  wire quiet = (acc_cnt >= 400) && (acc_cnt < 700);

  initial begin
    forever #5 clk = ~clk;
  end

  // Bit-serial reflected CRC-8, data bits taken LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ d[i];
      c = {c[6:0], 1'b0} ^ (fb ? fmp_pkg::HCRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Bit-serial reflected CRC-16, data bits taken LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? fmp_pkg::BCRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [7:0] pick(input int fill);
    return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
  endfunction

  // Advance the parser by one accepted byte and queue any result it yields
  task automatic parse_byte(input logic [7:0] b, input logic last);
    fmp_pkg::result_t r;
    bit               have;
    bit               done;
    int               pi;
    logic [7:0]       hrev;
    logic [15:0]      brev;
    r = '0;
    have = 1'b0;
    done = 1'b0;
    pi = int'(ps_pos);
    if (ps_phase == PH_DISCARD) begin
      if (last) begin
        ps_phase = PH_RECV;
        ps_pos = '0;
      end
    end else begin
      if (ps_pos == fmp_pkg::POS_SYNC) begin
        ps_hcrc = fmp_pkg::HCRC_INIT;
        ps_bcrc = fmp_pkg::BCRC_INIT;
      end
      if (pi <= 2) begin
        ps_hcrc = crc8_byte(ps_hcrc, b);
        ps_bcrc = crc16_byte(ps_bcrc, b);
      end else if (pi + 2 < int'(ps_len)) begin
        ps_bcrc = crc16_byte(ps_bcrc, b);
      end

      case (ps_pos)
        fmp_pkg::POS_SYNC: begin
          if (b != fmp_pkg::SYNC_BYTE) begin
            r.kind = fmp_pkg::KIND_REJECT;
            r.reject_reason = fmp_pkg::RSN_SYNC;
            have = 1'b1;
            done = 1'b1;
          end
        end
        fmp_pkg::POS_LEN_LO: ps_len = {2'b00, b};
        fmp_pkg::POS_LEN_HI: begin
          ps_len = {b[1:0], ps_len[7:0]};
          if (ps_len < fmp_pkg::MIN_LEN) begin
            r.kind = fmp_pkg::KIND_REJECT;
            r.reject_reason = fmp_pkg::RSN_SHORT;
            have = 1'b1;
            done = 1'b1;
          end
        end
        fmp_pkg::POS_HCRC: begin
          hrev = {<<{ps_hcrc}};
          ps_hdr_ok = (hrev == b);
        end
        fmp_pkg::POS_SENDER:  ps_sender = b;
        fmp_pkg::POS_RECVR:   ps_receiver = b;
        fmp_pkg::POS_ID_HI:   ps_msg_id[15:8] = b;
        fmp_pkg::POS_ID_LO:   ps_msg_id[7:0] = b;
        fmp_pkg::POS_FLAGS:   ps_flags = b;
        fmp_pkg::POS_CMD_SET: ps_cmd_set = b;
        fmp_pkg::POS_CMD_ID:  ps_cmd_id = b;
        default: begin
          if (pi + 2 < int'(ps_len)) begin
            r.kind = fmp_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.payload_index = ps_pos - fmp_pkg::POS_PAYLOAD;
            have = 1'b1;
          end else if (pi + 2 == int'(ps_len)) begin
            ps_trail_lo = b;
          end else begin
            brev = {<<{ps_bcrc}};
            r.kind = fmp_pkg::KIND_ACCEPT;
            r.crc_ok = ps_hdr_ok && (brev == {b, ps_trail_lo});
            have = 1'b1;
            done = 1'b1;
          end
        end
      endcase

      // Attach captured header to payload and accept results
      if (have && r.kind != fmp_pkg::KIND_REJECT) begin
        r.frame_length = ps_len;
        r.sender = ps_sender;
        r.receiver = ps_receiver;
        r.msg_id = ps_msg_id;
        r.flag_bits = ps_flags;
        r.command_set = ps_cmd_set;
        r.command_id = ps_cmd_id;
      end

      // Buffer end restarts the parser; an unfinished frame is cut short
      if (last) begin
        if (!done) begin
          r = '0;
          r.kind = fmp_pkg::KIND_REJECT;
          r.reject_reason = fmp_pkg::RSN_EARLY;
          have = 1'b1;
        end
        ps_phase = PH_RECV;
        ps_pos = '0;
      end else if (done) begin
        ps_phase = PH_DISCARD;
        ps_pos = '0;
      end else begin
        ps_pos = ps_pos + 10'd1;
      end
      if (have) begin
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_beat_t beat;
    beat.data = b;
    beat.last = last;
    pending_bytes.push_back(beat);
  endtask

  // Queue one buffer holding a frame, optionally with bad CRCs, cut short or followed by garbage
  task automatic build_frame(input int len, input int cut, input int extra,
                             input bit bad_hdr, input bit bad_body, input int fill);
    logic [7:0]  fr [$];
    logic [7:0]  v;
    logic [7:0]  hc;
    logic [7:0]  hr;
    logic [15:0] bc;
    logic [15:0] br;
    int          n;
    v = pick(fill);
    fr.push_back(fmp_pkg::SYNC_BYTE);
    fr.push_back(len[7:0]);
    fr.push_back({v[7:2], len[9:8]});
    if (len >= int'(fmp_pkg::MIN_LEN)) begin
      hc = fmp_pkg::HCRC_INIT;
      for (int i = 0; i < 3; i++) hc = crc8_byte(hc, fr[i]);
      hr = {<<{hc}};
      if (bad_hdr) hr = hr ^ 8'($urandom_range(1, 255));
      fr.push_back(hr);
      for (int i = 4; i < len - 2; i++) fr.push_back(pick(fill));
      bc = fmp_pkg::BCRC_INIT;
      for (int i = 0; i < len - 2; i++) bc = crc16_byte(bc, fr[i]);
      br = {<<{bc}};
      if (bad_body) br = br ^ 16'($urandom_range(1, 65535));
      fr.push_back(br[7:0]);
      fr.push_back(br[15:8]);
    end
    n = (cut > 0 && cut < fr.size()) ? cut : fr.size();
    for (int i = 0; i < n; i++) push_byte(fr[i], (i == n - 1) && (extra == 0));
    for (int i = 0; i < extra; i++) push_byte(pick(-1), i == extra - 1);
  endtask

  // Queue a buffer of random bytes, led by a sync byte or by a bad one
  task automatic emit_noise(input int n, input bit sync_first);
    logic [7:0] v;
    v = sync_first ? fmp_pkg::SYNC_BYTE : pick(-1);
    if (!sync_first && v == fmp_pkg::SYNC_BYTE) v = ~v;
    push_byte(v, n == 1);
    for (int i = 1; i < n; i++) push_byte(pick(-1), i == n - 1);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Reset sequencing, output stall and input beats, all on the falling edge
  always @(negedge clk) begin : drive_blk
    in_beat_t nxt;
    if (rst_hold < 5) begin
      rst_hold <= rst_hold + 1;
    end else begin
      rst_n <= 1'b1;
    end
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= nxt.data;
        in_last_of_buffer <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on accepted bytes, check accepted results against the oldest expectation
  always @(posedge clk) begin : mon_blk
    fmp_pkg::result_t want;
    cycle_cnt <= cycle_cnt + 1;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      parse_byte(in_data_byte, in_last_of_buffer);
      acc_cnt <= acc_cnt + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none got kind %0d", $time, out_kind);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        cmp_field("kind", 16'(want.kind), 16'(out_kind));
        cmp_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
        cmp_field("payload_index", 16'(want.payload_index), 16'(out_payload_index));
        cmp_field("frame_length", 16'(want.frame_length), 16'(out_frame_length));
        cmp_field("sender", 16'(want.sender), 16'(out_sender));
        cmp_field("receiver", 16'(want.receiver), 16'(out_receiver));
        cmp_field("msg_id", want.msg_id, out_msg_id);
        cmp_field("flag_bits", 16'(want.flag_bits), 16'(out_flag_bits));
        cmp_field("command_set", 16'(want.command_set), 16'(out_command_set));
        cmp_field("command_id", 16'(want.command_id), 16'(out_command_id));
        cmp_field("crc_ok", 16'(want.crc_ok), 16'(out_crc_ok));
        cmp_field("reject_reason", 16'(want.reject_reason), 16'(out_reject_reason));
      end
    end
  end

  initial begin : stim_blk
    int sel;
    int len;

    // Directed: length extremes, field extremes, CRC errors, rejects, early ends
    build_frame(13, 0, 0, 0, 0, 0);
    build_frame(24, 0, 3, 0, 0, 255);
    build_frame(16, 0, 0, 1, 0, -1);
    build_frame(16, 0, 2, 0, 1, -1);
    build_frame(12, 0, 0, 0, 0, -1);
    build_frame(0, 0, 4, 0, 0, -1);
    emit_noise(1, 0);
    emit_noise(6, 0);
    build_frame(20, 1, 0, 0, 0, -1);
    build_frame(20, 2, 0, 0, 0, -1);
    build_frame(20, 3, 0, 0, 0, -1);
    build_frame(20, 11, 0, 0, 0, -1);
    build_frame(20, 15, 0, 0, 0, -1);
    build_frame(20, 19, 0, 0, 0, -1);
    build_frame(261, 0, 0, 0, 0, -1);
    build_frame(1023, 14, 0, 0, 0, -1);

    // Random: mostly well-formed frames, the rest cut, short or noise
    while (pending_bytes.size() < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 2) ? $urandom_range(13, 200) : $urandom_range(13, 48);
      if (sel < 70) begin
        build_frame(len, 0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0,
                    $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, -1);
      end else if (sel < 80) begin
        build_frame(len, $urandom_range(1, len - 1), 0, 0, 0, -1);
      end else if (sel < 88) begin
        build_frame($urandom_range(0, 12), 0, $urandom_range(0, 3), 0, 0, -1);
      end else begin
        emit_noise($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      end
    end

    // Drain the stimulus, then the results, then let the pipeline settle
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule
